// ----- rtl/dcm_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive command mixer package
// Shared types and constants for the drive command mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcm_pkg;

  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AVOID  = 2'd1;

  localparam logic REG_DRIVE_MODE = 1'b0;
  localparam logic REG_SERVO_TRIM = 1'b1;

  localparam logic [9:0] MAX_RANGE_CM = 10'd150;

  localparam int MulAW = 18;
  localparam int MulBW = 17;
  localparam int MulPW = 28;

  typedef struct packed {
    logic [7:0] angle;
    logic       reverse;
    logic [7:0] duty_a;
    logic [7:0] duty_b;
  } dcm_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/drive_command_mixer.sv -----
// ----------------------------------------------------------------------------
// Drive command mixer
// Keeps the sonar distances and turns joystick ticks into servo and motor
// commands through a sequenced shared multiplier.
// ----------------------------------------------------------------------------
// out_valid_o is registered and rises once the sequencer reaches S_OUT with the output free.
// An accepted manual or avoid item passes start_q and then ten or four sequencer steps
// around the single shared multiplier, stalling the input; hold and spare items make no command.
// A result waiting in the output register can hold the last step and so stall the input.
// Reset clears mode and trim to zero and both stored distances to -1.
`default_nettype none

module drive_command_mixer #(
  parameter logic [9:0] MaxRangeCm = dcm_pkg::MAX_RANGE_CM
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] speed_stick_i,
  input  logic [9:0] steer_stick_i,
  input  logic [9:0] fine_stick_i,
  input  logic [7:0] ping_left_i,
  input  logic [7:0] ping_right_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] steer_angle_o,
  output logic       reverse_o,
  output logic [7:0] motor_a_duty_o,
  output logic [7:0] motor_b_duty_o
);
  import dcm_pkg::*;

  logic [1:0]        mode_q;
  logic [5:0]        trim_q;
  logic signed [8:0] left_q;
  logic signed [8:0] right_q;
  logic              start_q;
  logic [9:0]        speed_q;
  logic [9:0]        steer_q;
  logic [9:0]        fine_q;
  logic              out_valid_q;
  logic [7:0]        angle_out_q;
  logic              rev_out_q;
  logic [7:0]        duty_a_q;
  logic [7:0]        duty_b_q;

  logic     accept;
  logic     out_free;
  logic     busy;
  logic     done;
  dcm_cmd_t cmd;
  logic [8:0] angle_sum;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = start_q || busy;
  assign angle_sum = {1'b0, cmd.angle} + {3'b0, trim_q};

  dcm_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_q),
    .mode_i        (mode_q),
    .speed_stick_i (speed_q),
    .steer_stick_i (steer_q),
    .fine_stick_i  (fine_q),
    .left_i        (left_q),
    .right_i       (right_q),
    .out_free_i    (out_free),
    .busy_o        (busy),
    .done_o        (done),
    .cmd_o         (cmd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_MANUAL;
      trim_q      <= 6'd0;
      left_q      <= -9'sd1;
      right_q     <= -9'sd1;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DRIVE_MODE: mode_q <= cfg_data_i[1:0];
          REG_SERVO_TRIM: trim_q <= cfg_data_i;
          default: ;
        endcase
      end
      start_q <= accept && (mode_q == MODE_MANUAL || mode_q == MODE_AVOID);
      if (accept) begin
        if (ping_left_i != 8'd0 && {2'b0, ping_left_i} < MaxRangeCm) begin
          left_q <= {1'b0, ping_left_i};
        end
        if (ping_right_i != 8'd0 && {2'b0, ping_right_i} < MaxRangeCm) begin
          right_q <= {1'b0, ping_right_i};
        end
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      speed_q <= speed_stick_i;
      steer_q <= steer_stick_i;
      fine_q  <= fine_stick_i;
    end
    if (done) begin
      angle_out_q <= angle_sum[7:0];
      rev_out_q   <= cmd.reverse;
      duty_a_q    <= cmd.duty_a;
      duty_b_q    <= cmd.duty_b;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign steer_angle_o  = angle_out_q;
  assign reverse_o      = rev_out_q;
  assign motor_a_duty_o = duty_a_q;
  assign motor_b_duty_o = duty_b_q;

endmodule

`default_nettype wire

// ----- rtl/dcm_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// One unsigned multiplier with a registered product, reused by the sequencer.
// The product holds while the enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [dcm_pkg::MulAW-1:0]  a_i,
  input  logic [dcm_pkg::MulBW-1:0]  b_i,
  output logic [dcm_pkg::MulPW-1:0]  p_o
);
  import dcm_pkg::*;

  logic [MulAW+MulBW-1:0] full;
  logic [MulPW-1:0]       p_q;

  assign full = {{MulBW{1'b0}}, a_i} * {{MulAW{1'b0}}, b_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= full[MulPW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- rtl/dcm_core.sv -----
// ----------------------------------------------------------------------------
// Drive command sequencer
// Steps one item through the shared multiplier to form angle and duties.
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          mode_i,
  input  logic [9:0]          speed_stick_i,
  input  logic [9:0]          steer_stick_i,
  input  logic [9:0]          fine_stick_i,
  input  logic signed [8:0]   left_i,
  input  logic signed [8:0]   right_i,
  input  logic                out_free_i,
  output logic                busy_o,
  output logic                done_o,
  output dcm_pkg::dcm_cmd_t   cmd_o
);
  import dcm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SPD, S_STX, S_STQ, S_FINE, S_ANG, S_RED, S_MIX, S_DIV, S_OUT
  } state_e;

  state_e     state_q;
  logic [7:0] angle_q;
  logic [7:0] spd_q;
  logic       back_q;
  logic [6:0] q1_q;

  logic             mul_en;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;

  logic [8:0] stick_mag;
  logic [9:0] fine_mag;
  logic       fine_neg;
  logic [7:0] speed_raw;
  logic [7:0] speed_fl;
  logic [7:0] speed_man;
  logic [4:0] q2;
  logic [7:0] angle_new;
  logic [7:0] dist_full;
  logic [4:0] redux;
  logic [5:0] fac;
  logic [7:0] duty;

  assign mul_en = (state_q != S_OUT);

  dcm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    if (speed_stick_i[9]) begin
      stick_mag = speed_stick_i[8:0];
    end else if (speed_stick_i == 10'd0) begin
      stick_mag = 9'd511;
    end else begin
      stick_mag = 9'(10'd512 - speed_stick_i);
    end
    fine_neg = !fine_stick_i[9];
    fine_mag = fine_neg ? (10'd512 - fine_stick_i) : {1'b0, fine_stick_i[8:0]};

    speed_raw = prod[25:18];
    speed_fl  = (speed_raw < 8'd90) ? 8'd90 : speed_raw;
    if (!back_q && (left_i < 9'sd10 || right_i < 9'sd10)) begin
      speed_man = 8'd0;
    end else if (!back_q && (left_i < 9'sd30 || right_i < 9'sd30)) begin
      speed_man = 8'd90;
    end else begin
      speed_man = speed_fl;
    end

    q2 = prod[14:10];
    if (fine_neg) begin
      angle_new = 8'd135 - {1'b0, q1_q} + {3'b0, q2};
    end else begin
      angle_new = 8'd135 - {1'b0, q1_q} - {3'b0, q2};
    end

    dist_full = (angle_q >= 8'd90) ? (angle_q - 8'd90) : (8'd90 - angle_q);
    redux     = prod[22:18];
    fac       = 6'd45 - {1'b0, redux};
    duty      = prod[26:19];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQ: begin
        mul_a = MulAW'(stick_mag);
        mul_b = MulBW'(stick_mag);
      end
      S_SPD: begin
        mul_a = prod[17:0];
        mul_b = MulBW'(255);
      end
      S_STX: begin
        mul_a = MulAW'(steer_stick_i);
        mul_b = MulBW'(90);
      end
      S_STQ: begin
        mul_a = {1'b0, prod[16:0]} + 18'd1;
        mul_b = MulBW'(1025);
      end
      S_FINE: begin
        mul_a = MulAW'(fine_mag);
        mul_b = MulBW'(41);
      end
      S_RED: begin
        mul_a = MulAW'(dist_full[6:0]);
        mul_b = MulBW'(91770);
      end
      S_MIX: begin
        mul_a = MulAW'(spd_q);
        mul_b = MulBW'(fac);
      end
      S_DIV: begin
        mul_a = MulAW'(prod[13:0]);
        mul_b = MulBW'(11651);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      angle_q <= 8'd0;
      spd_q   <= 8'd0;
      back_q  <= 1'b0;
      q1_q    <= 7'd0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (mode_i == MODE_AVOID) begin
              state_q <= S_RED;
              if (left_i < 9'sd20 && right_i < 9'sd20) begin
                angle_q <= (left_i < right_i) ? 8'd135 : 8'd45;
                back_q  <= 1'b1;
                spd_q   <= 8'd120;
              end else if (left_i < 9'sd40 || right_i < 9'sd40) begin
                angle_q <= (left_i > right_i) ? 8'd120 : 8'd60;
                back_q  <= 1'b0;
                spd_q   <= 8'd120;
              end else begin
                angle_q <= 8'd90;
                back_q  <= 1'b0;
                spd_q   <= 8'd255;
              end
            end else begin
              state_q <= S_SQ;
              back_q  <= speed_stick_i[9] && (speed_stick_i[8:0] != 9'd0);
            end
          end
        end
        S_SQ:   state_q <= S_SPD;
        S_SPD:  state_q <= S_STX;
        S_STX: begin
          spd_q   <= speed_man;
          state_q <= S_STQ;
        end
        S_STQ:  state_q <= S_FINE;
        S_FINE: begin
          q1_q    <= prod[26:20];
          state_q <= S_ANG;
        end
        S_ANG: begin
          angle_q <= angle_new;
          state_q <= S_RED;
        end
        S_RED:  state_q <= S_MIX;
        S_MIX:  state_q <= S_DIV;
        S_DIV:  state_q <= S_OUT;
        S_OUT: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.angle   = angle_q;
    cmd_o.reverse = back_q;
    cmd_o.duty_a  = spd_q;
    cmd_o.duty_b  = spd_q;
    if (angle_q > 8'd90) begin
      cmd_o.duty_b = duty;
    end else if (angle_q < 8'd90) begin
      cmd_o.duty_a = duty;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT) && out_free_i;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Drive command mixer testbench
// Sends joystick and sonar items through the mixer in manual, avoid, hold and spare
// modes under several trim settings. A predictor keeps its own copy of the
// stored distances and registers, and every command that comes out is
// checked field by field against the oldest predicted one. Both sides idle
// and stall at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcm_pkg::*;

  localparam logic [1:0] MODE_HOLD  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int STICK_CENTRE   = 512;
  localparam int STICK_CLAMP    = 511;
  localparam int SQ_FULL        = 262144;
  localparam int SPEED_FLOOR    = 90;
  localparam int FINE_DIV       = 25;
  localparam int AVOID_SPEED    = 120;
  localparam int TURN_DIV       = 45;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int MAX_SHOWN      = 10;
  localparam int PHASES         = 9;

  typedef struct packed {
    logic [9:0] speed;
    logic [9:0] steer;
    logic [9:0] fine;
    logic [7:0] ping_l;
    logic [7:0] ping_r;
  } tick_t;

  localparam logic [1:0] PHASE_MODE [PHASES] = '{
    MODE_MANUAL, MODE_MANUAL, MODE_AVOID, MODE_HOLD, MODE_MANUAL,
    MODE_AVOID, MODE_SPARE, MODE_MANUAL, MODE_AVOID
  };
  localparam logic [5:0] PHASE_TRIM [PHASES] = '{
    6'd0, 6'd63, 6'd31, 6'd7, 6'd50, 6'd0, 6'd12, 6'd20, 6'd63
  };
  localparam int PHASE_ITEMS [PHASES] = '{210, 210, 210, 40, 210, 210, 40, 210, 210};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [5:0] cfg_data_i  = '0;
  logic       in_valid_i  = 1'b0;
  tick_t      cur_tick    = '0;
  logic       out_stall_i = 1'b0;
  logic       rx_hold_req = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] steer_angle_o;
  logic       reverse_o;
  logic [7:0] motor_a_duty_o;
  logic [7:0] motor_b_duty_o;

  tick_t    tick_q[$];
  dcm_cmd_t cmd_exp_q[$];
  dcm_cmd_t got_cmd;
  dcm_cmd_t want_cmd;

  logic [1:0]        mode_cfg = MODE_MANUAL;
  logic [5:0]        trim_cfg = '0;
  logic signed [8:0] left_cm  = -9'sd1;
  logic signed [8:0] right_cm = -9'sd1;

  int send_idle_pct = 18;
  int recv_idle_pct = 57;
  int hold_left     = 0;
  int fail_cnt      = 0;

  drive_command_mixer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .speed_stick_i  (cur_tick.speed),
    .steer_stick_i  (cur_tick.steer),
    .fine_stick_i   (cur_tick.fine),
    .ping_left_i    (cur_tick.ping_l),
    .ping_right_i   (cur_tick.ping_r),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .steer_angle_o  (steer_angle_o),
    .reverse_o      (reverse_o),
    .motor_a_duty_o (motor_a_duty_o),
    .motor_b_duty_o (motor_b_duty_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic dcm_cmd_t mix_cmd(input int angle, input bit back, input int spd);
    dcm_cmd_t cmd;
    int duty_a;
    int duty_b;
    int redux;
    int shown;
    duty_a = spd;
    duty_b = spd;
    if (angle > 90) begin
      redux  = (angle - 90) * 35 / 100;
      duty_b = spd * (TURN_DIV - redux) / TURN_DIV;
    end else if (angle < 90) begin
      redux  = (90 - angle) * 35 / 100;
      duty_a = spd * (TURN_DIV - redux) / TURN_DIV;
    end
    shown       = angle + int'(trim_cfg);
    cmd.angle   = shown[7:0];
    cmd.reverse = back;
    cmd.duty_a  = duty_a[7:0];
    cmd.duty_b  = duty_b[7:0];
    return cmd;
  endfunction

  function automatic void predict_cmd(input tick_t t);
    int  spd_v;
    int  steer_v;
    int  fine_v;
    int  lcm;
    int  rcm;
    int  off;
    int  speed;
    int  angle;
    bit  back;
    if (t.ping_l > 0 && t.ping_l < MAX_RANGE_CM) left_cm = {1'b0, t.ping_l};
    if (t.ping_r > 0 && t.ping_r < MAX_RANGE_CM) right_cm = {1'b0, t.ping_r};
    lcm     = left_cm;
    rcm     = right_cm;
    spd_v   = t.speed;
    steer_v = t.steer;
    fine_v  = t.fine;
    if (mode_cfg == MODE_MANUAL) begin
      off  = spd_v - STICK_CENTRE;
      back = off > 0;
      if (off > STICK_CLAMP) off = STICK_CLAMP;
      if (off < -STICK_CLAMP) off = -STICK_CLAMP;
      speed = off * off * 255 / SQ_FULL;
      if (speed < SPEED_FLOOR) speed = SPEED_FLOOR;
      angle = 135 - (steer_v * 90) / 1023 - (fine_v - STICK_CENTRE) / FINE_DIV;
      if (!back && (lcm < 10 || rcm < 10)) begin
        speed = 0;
      end else if (!back && (lcm < 30 || rcm < 30)) begin
        speed = (speed < SPEED_FLOOR) ? speed : SPEED_FLOOR;
      end
      cmd_exp_q.push_back(mix_cmd(angle, back, speed));
    end else if (mode_cfg == MODE_AVOID) begin
      if (lcm < 20 && rcm < 20) begin
        cmd_exp_q.push_back(mix_cmd((lcm < rcm) ? 135 : 45, 1'b1, AVOID_SPEED));
      end else if (lcm < 40 || rcm < 40) begin
        cmd_exp_q.push_back(mix_cmd((lcm > rcm) ? 120 : 60, 1'b0, AVOID_SPEED));
      end else begin
        cmd_exp_q.push_back(mix_cmd(90, 1'b0, 255));
      end
    end
  endfunction

  function automatic logic [9:0] rand_stick();
    int v;
    case ($urandom_range(5))
      0: v = ($urandom_range(1) != 0) ? 1023 : 0;
      1: v = $urandom_range(542, 482);
      2: v = ($urandom_range(1) != 0) ? 511 : 512;
      default: v = $urandom_range(1023, 0);
    endcase
    return v[9:0];
  endfunction

  function automatic logic [7:0] rand_ping();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = $urandom_range(255, 150);
      2: v = $urandom_range(9, 1);
      3: v = $urandom_range(19, 10);
      4: v = $urandom_range(29, 20);
      5: v = $urandom_range(39, 30);
      default: v = $urandom_range(149, 1);
    endcase
    return v[7:0];
  endfunction

  task automatic program_regs(input logic [1:0] mode, input logic [5:0] trim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DRIVE_MODE;
    cfg_data_i  <= {4'b0000, mode};
    @(posedge clk_i);
    cfg_index_i <= REG_SERVO_TRIM;
    cfg_data_i  <= trim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_cfg = mode;
    trim_cfg = trim;
  endtask

  // Waits until every queued item is sent and every predicted command has come out,
  // then leaves room for an item in flight that causes no command.
  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (cmd_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_cmd(cur_tick);
      if (!(in_valid_i && in_stall_o)) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_tick   <= tick_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_hold_req) begin
        hold_left = RX_HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_cmd = {steer_angle_o, reverse_o, motor_a_duty_o, motor_b_duty_o};
      if (cmd_exp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN) begin
          $display("Unexpected command: angle %0d rev %0d a %0d b %0d",
                   got_cmd.angle, got_cmd.reverse, got_cmd.duty_a, got_cmd.duty_b);
        end
      end else begin
        want_cmd = cmd_exp_q.pop_front();
        if (got_cmd !== want_cmd) begin
          fail_cnt++;
          if (fail_cnt <= MAX_SHOWN) begin
            $display("Mismatch: expected angle %0d rev %0d a %0d b %0d,",
                     want_cmd.angle, want_cmd.reverse, want_cmd.duty_a, want_cmd.duty_b,
                     " got angle %0d rev %0d a %0d b %0d",
                     got_cmd.angle, got_cmd.reverse, got_cmd.duty_a, got_cmd.duty_b);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tick_t t;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Avoid mode with no distance measured yet backs up.
    program_regs(MODE_AVOID, 6'd0);
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd0, 8'd0});
    tick_q.push_back('{10'd1023, 10'd1023, 10'd1023, 8'd0, 8'd3});
    drain();

    // Manual mode: stick extremes, out-of-range pings and the obstacle bands.
    program_regs(MODE_MANUAL, 6'd0);
    tick_q.push_back('{10'd0, 10'd512, 10'd512, 8'd0, 8'd0});
    tick_q.push_back('{10'd1023, 10'd0, 10'd0, 8'd0, 8'd0});
    tick_q.push_back('{10'd1023, 10'd1023, 10'd1023, 8'd150, 8'd255});
    tick_q.push_back('{10'd0, 10'd1023, 10'd0, 8'd200, 8'd5});
    tick_q.push_back('{10'd0, 10'd0, 10'd1023, 8'd149, 8'd149});
    tick_q.push_back('{10'd100, 10'd300, 10'd700, 8'd25, 8'd60});
    tick_q.push_back('{10'd200, 10'd700, 10'd400, 8'd12, 8'd9});
    tick_q.push_back('{10'd512, 10'd511, 10'd512, 8'd1, 8'd1});
    tick_q.push_back('{10'd513, 10'd600, 10'd900, 8'd1, 8'd1});
    tick_q.push_back('{10'd511, 10'd0, 10'd511, 8'd10, 8'd30});
    tick_q.push_back('{10'd300, 10'd512, 10'd537, 8'd29, 8'd145});
    drain();

    // Avoid mode across its distance bands, with trim.
    program_regs(MODE_AVOID, 6'd50);
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd15, 8'd18});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd18, 8'd15});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd17, 8'd17});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd35, 8'd100});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd100, 8'd39});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd40, 8'd40});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd149, 8'd0});
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd19, 8'd25});
    drain();

    // Hold and the unused mode give nothing but still update the distances.
    program_regs(MODE_HOLD, 6'd63);
    tick_q.push_back('{10'd1023, 10'd0, 10'd0, 8'd5, 8'd5});
    drain();
    program_regs(MODE_SPARE, 6'd63);
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd0, 8'd0});
    drain();
    program_regs(MODE_MANUAL, 6'd63);
    tick_q.push_back('{10'd0, 10'd0, 10'd0, 8'd0, 8'd0});
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_regs(PHASE_MODE[p], PHASE_TRIM[p]);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        t.speed  = rand_stick();
        t.steer  = rand_stick();
        t.fine   = rand_stick();
        t.ping_l = rand_ping();
        t.ping_r = rand_ping();
        tick_q.push_back(t);
      end
      if (p == 1) begin
        @(posedge clk_i);
        rx_hold_req <= 1'b1;
        @(posedge clk_i);
        rx_hold_req <= 1'b0;
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
